/* rtl/buddy_free_merge_top_macros.svh */
// Assertion macros for the buddy free-and-merge block.
// Used by buddy_free_merge_top; expects clk_i and rst_ni in scope.
`ifndef BUDDY_FREE_MERGE_TOP_MACROS_SVH
`define BUDDY_FREE_MERGE_TOP_MACROS_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define BFM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bfm_pkg.sv */
// Shared types and constants for the buddy free-and-merge block.
// No dependencies; imported by the controller and the top level.
package bfm_pkg;

  localparam int IDX_W   = 9;
  localparam int LVL_W   = 4;
  localparam int TAG_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 1'd1;

  localparam logic [LVL_W-1:0] MAX_LEVEL_RST = 4'd9;

  typedef enum logic [1:0] {
    ST_FREED     = 2'd0,
    ST_BAD_TAG   = 2'd1,
    ST_BAD_LEVEL = 2'd2
  } status_e;

  typedef struct packed {
    logic             pool;
    logic [IDX_W-1:0] block_index;
    logic [LVL_W-1:0] level;
    logic [TAG_W-1:0] header_tag;
  } bfm_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] final_index;
    logic [LVL_W-1:0] final_level;
  } bfm_rsp_t;

  typedef struct packed {
    logic [LVL_W-1:0] max_level;
    logic [TAG_W-1:0] magic_word;
  } bfm_cfg_t;

endpackage

/* rtl/bfm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bfm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bfm_ctrl.sv */
// Sequencer for the free-and-merge walk: clearing pass, request checks and
// one read-modify-write of the free map per level. Depends on bfm_pkg.
module bfm_ctrl
  import bfm_pkg::*;
#(
  parameter int LEVELS = 10,
  parameter int POOLS  = 2,
  parameter int RW     = 5,
  parameter int AW     = 14,
  parameter int DEPTH  = 10240
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfm_cfg_t      cfg_i,
  input  logic          start,
  output logic          busy,
  input  bfm_req_t      req_i,
  output logic          rsp_valid_o,
  output bfm_rsp_t      rsp_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [1:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [1:0]    mem_rdata_i
);

  localparam int PW      = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int TOP_CAP = (LEVELS - 1 < IDX_W) ? LEVELS - 1 : IDX_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_e;

  state_e           state_q;
  logic [PW-1:0]    pool_q;
  logic [IDX_W-1:0] idx_q;
  logic [LVL_W-1:0] lvl_q;
  logic [AW-1:0]    clr_cnt_q;
  logic             rsp_valid_q;
  bfm_rsp_t         rsp_q;

  logic [LVL_W-1:0] top_lvl;
  logic [PW-1:0]    pool_in;
  logic [IDX_W:0]   low_mask;
  logic [IDX_W-1:0] idx_aligned;
  logic [IDX_W-1:0] cur_bit, nxt_bit;
  logic [IDX_W-1:0] nxt_idx;
  logic [LVL_W-1:0] nxt_lvl;
  logic             own_hi, bud_free, merge;
  logic [AW-1:0]    cur_addr, nxt_addr;

  // One-hot of the level's index bit; zero when the level is the full index.
  function automatic logic [IDX_W-1:0] level_bit(input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] m;
    m = '0;
    if (lvl < LVL_W'(IDX_W)) begin
      m = IDX_W'(1) << lvl;
    end
    return m;
  endfunction

  // One memory word holds both buddies of a pair: the word is keyed by the
  // index with the level bit cleared, bit 1 is the upper buddy.
  function automatic logic [AW-1:0] map_addr(input logic [PW-1:0]    pool,
                                             input logic [LVL_W-1:0] lvl,
                                             input logic [IDX_W-1:0] key);
    logic [RW-1:0] row;
    row = RW'(RW'(pool) * RW'(LEVELS)) + RW'(lvl);
    return AW'({row, key});
  endfunction

  assign top_lvl = (cfg_i.max_level > LVL_W'(TOP_CAP)) ? LVL_W'(TOP_CAP)
                                                         : cfg_i.max_level;
  assign pool_in = (POOLS > 1) ? PW'(req_i.pool) : '0;

  assign low_mask    = ((IDX_W+1)'(1) << req_i.level) - (IDX_W+1)'(1);
  assign idx_aligned = req_i.block_index & ~low_mask[IDX_W-1:0];

  assign cur_bit  = level_bit(lvl_q);
  assign own_hi   = |(idx_q & cur_bit);
  assign bud_free = own_hi ? mem_rdata_i[0] : mem_rdata_i[1];
  assign merge    = (lvl_q < top_lvl) && bud_free;
  assign nxt_idx  = idx_q & ~cur_bit;
  assign nxt_lvl  = lvl_q + LVL_W'(1);
  assign nxt_bit  = level_bit(nxt_lvl);
  assign cur_addr = map_addr(pool_q, lvl_q, idx_q & ~cur_bit);
  assign nxt_addr = map_addr(pool_q, nxt_lvl, nxt_idx & ~nxt_bit);

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_addr;
    mem_wdata_o = 2'b00;
    mem_re_o    = 1'b0;
    mem_raddr_o = cur_addr;
    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_cnt_q;
      end
      S_READ: begin
        mem_re_o = 1'b1;
      end
      S_CHECK: begin
        mem_we_o = 1'b1;
        if (merge) begin
          // Both buddies leave this level; fetch the parent pair meanwhile.
          mem_wdata_o = 2'b00;
          mem_re_o    = 1'b1;
          mem_raddr_o = nxt_addr;
        end else begin
          mem_wdata_o = mem_rdata_i | (own_hi ? 2'b10 : 2'b01);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pool_q      <= '0;
      idx_q       <= '0;
      lvl_q       <= '0;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (req_i.header_tag != cfg_i.magic_word) begin
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{status: ST_BAD_TAG, final_index: '0, final_level: '0};
            end else if (req_i.level > top_lvl) begin
              rsp_valid_q <= 1'b1;
              rsp_q       <= '{status: ST_BAD_LEVEL, final_index: '0, final_level: '0};
            end else begin
              pool_q  <= pool_in;
              idx_q   <= idx_aligned;
              lvl_q   <= req_i.level;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (merge) begin
            idx_q <= nxt_idx;
            lvl_q <= nxt_lvl;
          end else begin
            rsp_valid_q <= 1'b1;
            rsp_q       <= '{status: ST_FREED, final_index: idx_q, final_level: lvl_q};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* rtl/buddy_free_merge_top.sv */
// Buddy free-and-merge top level: configuration registers, free-map RAM, sequencer.
// A rejected request (bad tag or level) returns its result in the cycle after acceptance.
// A valid free walks up from its level through m merges (0 to 9), with one free-map
// read-modify-write per level visited; busy stays high until the result, so no new request is taken.
// After reset a clearing pass writes every free-map word, POOLS*LEVELS*512 words
// (10240 by default), with busy high; configuration writes are taken at all times.
module buddy_free_merge_top
  import bfm_pkg::*;
#(
  parameter int LEVELS = 10,
  parameter int POOLS  = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  bfm_req_t              req_i,
  output logic                  rsp_valid_o,
  output bfm_rsp_t              rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "buddy_free_merge_top_macros.svh"

  localparam int ROWS  = POOLS * LEVELS;
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + IDX_W;
  localparam int DEPTH = ROWS * (1 << IDX_W);

  logic [LVL_W-1:0] max_level_q;
  logic [TAG_W-1:0] magic_word_q;
  bfm_cfg_t         cfg;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q  <= MAX_LEVEL_RST;
      magic_word_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        CFG_MAX_LEVEL:  max_level_q  <= cfg_data_i[LVL_W-1:0];
        CFG_MAGIC_WORD: magic_word_q <= cfg_data_i[TAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{max_level: max_level_q, magic_word: magic_word_q};

  bfm_ctrl #(
    .LEVELS (LEVELS),
    .POOLS  (POOLS),
    .RW     (RW),
    .AW     (AW),
    .DEPTH  (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bfm_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_free_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // A result beat is only produced while the sequencer is idle.
  `BFM_ASSERT_IMPL(a_rsp_idle, rsp_valid_o, !busy, "result beat while busy")
  // An accepted request either starts a walk or answers in the next cycle.
  `BFM_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_valid_o,
                   "accepted request neither started nor answered")
  // The merge step reads the parent pair while writing the child pair.
  `BFM_ASSERT_IMPL(a_no_rw_same_word, mem_we && mem_re, mem_waddr != mem_raddr,
                   "free map read and written at the same word")
  // Rejected requests carry a zero index and level.
  `BFM_ASSERT_IMPL(a_reject_zero, rsp_valid_o && (rsp_o.status != ST_FREED),
                   (rsp_o.final_index == '0) && (rsp_o.final_level == '0),
                   "rejected request with nonzero index or level")

endmodule

/* tb/sv/buddy_merge_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the buddy free-and-merge block: predicts each free request and checks results.
// Depends on bfm_pkg for the request, result and register types.
module buddy_merge_checker
  import bfm_pkg::*;
#(
  parameter int LEVELS = 10,
  parameter int POOLS  = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  bfm_req_t              req_i,
  input  logic                  rsp_valid_i,
  input  bfm_rsp_t              rsp_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    outstanding_o,
  output int                    mismatches_o,
  output int                    checked_o
);

  localparam int SLOTS = 1 << IDX_W;
  localparam int PRINT_CAP = 40;

  bit               free_bits [POOLS][LEVELS][SLOTS];
  logic [LVL_W-1:0] max_level_q;
  logic [TAG_W-1:0] magic_q;
  bfm_rsp_t         rsp_expected [$];
  bfm_rsp_t         want;

  task automatic report_mismatch(input string msg);
    if (mismatches_o < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  // Check one request's tag and level; if valid, free the block and climb while the buddy at the current level is free.
  task automatic merge_free(input bfm_req_t r, output bfm_rsp_t e);
    int p;
    int lvl;
    int top;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] bud;
    p   = int'(r.pool) % POOLS;
    idx = r.block_index;
    lvl = int'(r.level);
    top = int'(max_level_q);
    if (top > LEVELS - 1) top = LEVELS - 1;
    if (top > IDX_W) top = IDX_W;
    e = '0;
    if (r.header_tag != magic_q) begin
      e.status = ST_BAD_TAG;
    end else if (lvl > top) begin
      e.status = ST_BAD_LEVEL;
    end else begin
      for (int b = 0; b < lvl; b++) idx[b] = 1'b0;
      while (lvl < top) begin
        bud = idx ^ (IDX_W'(1) << lvl);
        if (!free_bits[p][lvl][bud]) break;
        free_bits[p][lvl][bud] = 1'b0;
        free_bits[p][lvl][idx] = 1'b0;
        idx[lvl] = 1'b0;
        lvl++;
      end
      free_bits[p][lvl][idx] = 1'b1;
      e.status      = ST_FREED;
      e.final_index = idx;
      e.final_level = LVL_W'(lvl);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (free_bits[p, l, i]) free_bits[p][l][i] = 1'b0;
      max_level_q = MAX_LEVEL_RST;
      magic_q     = '0;
      rsp_expected.delete();
      outstanding_o <= 0;
    end else begin
      if (rsp_valid_i) begin
        if (rsp_expected.size() == 0) begin
          report_mismatch($sformatf(
            "result beat with nothing pending: status %0d index %0d level %0d",
            rsp_i.status, rsp_i.final_index, rsp_i.final_level));
        end else begin
          want = rsp_expected.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp_i.status, want.status));
          if (rsp_i.final_index !== want.final_index)
            report_mismatch($sformatf("final_index %0d, want %0d",
                                      rsp_i.final_index, want.final_index));
          if (rsp_i.final_level !== want.final_level)
            report_mismatch($sformatf("final_level %0d, want %0d",
                                      rsp_i.final_level, want.final_level));
          checked_o++;
        end
      end
      // A request beat taken at the same edge as a register write still sees the old value.
      if (start_i && !busy_i) begin
        merge_free(req_i, want);
        rsp_expected.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_i == CFG_MAX_LEVEL) max_level_q = cfg_data_i[LVL_W-1:0];
        else if (cfg_idx_i == CFG_MAGIC_WORD) magic_q = cfg_data_i[TAG_W-1:0];
      end
      outstanding_o <= rsp_expected.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the buddy free-and-merge testbench: clock, reset, stimulus and verdict.
// Depends on bfm_pkg, buddy_free_merge_top and buddy_merge_checker.
module tb;
  import bfm_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 204;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  bfm_req_t              req_i       = '0;
  logic                  rsp_valid_o;
  bfm_rsp_t              rsp_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int               outstanding;
  int               mismatches;
  int               checked;
  int               idle_pct      = 0;
  int               max_level_cur = 9;
  logic [TAG_W-1:0] magic_cur     = '0;
  int               items_sent    = 0;
  int               settings_done = 0;
  int               idle_cycles   = 0;

  buddy_free_merge_top #(
    .LEVELS(10),
    .POOLS (2)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  buddy_merge_checker #(
    .LEVELS(10),
    .POOLS (2)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_i        (rsp_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .outstanding_o(outstanding),
    .mismatches_o (mismatches),
    .checked_o    (checked)
  );

  always #10 clk_i = ~clk_i;

  // Any accepted beat on any channel resets the watchdog.
  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || rsp_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bfm_req_t mk_req(input logic pool, input int idx, input int lvl,
                                      input logic [TAG_W-1:0] tag);
    bfm_req_t r;
    r.pool        = pool;
    r.block_index = IDX_W'(idx);
    r.level       = LVL_W'(lvl);
    r.header_tag  = tag;
    return r;
  endfunction

  // Both registers go out as back-to-back beats with valid held high.
  task automatic configure(input int ml, input logic [TAG_W-1:0] mw);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= CFG_MAX_LEVEL;
    cfg_data_i  <= CFG_DATA_W'(ml);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_idx_i   <= CFG_MAGIC_WORD;
    cfg_data_i  <= CFG_DATA_W'(mw);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    max_level_cur = ml;
    magic_cur     = mw;
    settings_done++;
  endtask

  // A request beat is taken at the edge where start is high and busy is low.
  task automatic send_req(input bfm_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    bfm_req_t         r;
    int               top;
    int               lvl;
    int               k;
    int               base;
    int               sent;
    int               kind;
    int               j;
    int               offs [$];
    logic             pl;
    logic [TAG_W-1:0] tag;
    int               phase_max  [PHASES];
    int               phase_idle [PHASES];
    logic [TAG_W-1:0] phase_magic[PHASES];

    phase_max   = '{9, 0, 15, 3, 9, 6, 1, 12};
    phase_idle  = '{0, 70, 23, 0, 70, 23, 70, 0};
    phase_magic = '{32'h0, 32'hFFFF_FFFF, $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom()};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part; the first request also waits out the clearing pass.
    configure(9, 32'hFFFF_FFFF);
    send_req(mk_req(1'b0, 0, 0, 32'h0));
    send_req(mk_req(1'b1, 511, 15, magic_cur));
    send_req(mk_req(1'b0, 0, 10, magic_cur));
    send_req(mk_req(1'b0, 511, 9, magic_cur));
    send_req(mk_req(1'b0, 511, 9, magic_cur));
    send_req(mk_req(1'b1, 0, 0, magic_cur));
    send_req(mk_req(1'b1, 1, 0, magic_cur));
    send_req(mk_req(1'b1, 3, 1, magic_cur));
    send_req(mk_req(1'b1, 5, 0, magic_cur));
    send_req(mk_req(1'b1, 5, 0, magic_cur));
    send_req(mk_req(1'b1, 4, 0, magic_cur));
    send_req(mk_req(1'b1, 6, 1, magic_cur));
    send_req(mk_req(1'b1, 256, 8, magic_cur));
    send_req(mk_req(1'b1, 0, 8, magic_cur));
    send_req(mk_req(1'b1, 0, 3, magic_cur));
    send_req(mk_req(1'b0, 0, 0, 32'hFFFF_FFFE));
    send_req(mk_req(1'b1, 1, 0, 32'h0));
    drain();
    configure(0, 32'hFFFF_FFFF);
    send_req(mk_req(1'b0, 3, 0, magic_cur));
    send_req(mk_req(1'b0, 2, 0, magic_cur));
    send_req(mk_req(1'b0, 0, 1, magic_cur));
    drain();
    configure(15, 32'h0);
    send_req(mk_req(1'b0, 0, 9, magic_cur));
    send_req(mk_req(1'b0, 0, 10, magic_cur));
    send_req(mk_req(1'b1, 0, 0, 32'hFFFF_FFFF));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      configure(phase_max[ph], phase_magic[ph]);
      idle_pct = phase_idle[ph];
      top = (max_level_cur > IDX_W) ? IDX_W : max_level_cur;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          // Free every sub-block of one aligned region in random order, so merges cascade.
          lvl  = $urandom_range(top, 0);
          k    = $urandom_range((top - lvl > 3) ? 3 : top - lvl, 0);
          base = $urandom_range(511) & ~((1 << (lvl + k)) - 1);
          pl   = 1'($urandom_range(1));
          offs.delete();
          for (j = 0; j < (1 << k); j++) offs.push_back(base + (j << lvl));
          while (offs.size() > 0) begin
            j = $urandom_range(offs.size() - 1);
            r = mk_req(pl, offs[j], lvl, magic_cur);
            if (lvl > 0 && $urandom_range(3) == 0)
              r.block_index = r.block_index | IDX_W'($urandom_range((1 << lvl) - 1));
            offs.delete(j);
            send_req(r);
            sent++;
          end
        end else begin
          if (kind < 75) begin
            r = mk_req(1'($urandom_range(1)), $urandom_range(511), $urandom_range(top, 0),
                       magic_cur);
          end else if (kind < 88) begin
            r = mk_req(1'($urandom_range(1)), $urandom_range(511), $urandom_range(15),
                       magic_cur);
          end else begin
            tag = $urandom_range(1) ? $urandom() : magic_cur ^ (32'h1 << $urandom_range(31));
            r = mk_req(1'($urandom_range(1)), $urandom_range(511), $urandom_range(15), tag);
          end
          send_req(r);
          sent++;
        end
      end
    end
    drain();

    $display("summary: %0d free requests over %0d register settings, %0d results checked",
             items_sent, settings_done, checked);
    $display("summary: max_level 0 to 15, tag words 0, all ones and random, sender idle 0/23/70");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* buddy_free_merge_top.f */
+incdir+rtl
rtl/bfm_pkg.sv
rtl/bfm_ram.sv
rtl/bfm_ctrl.sv
rtl/buddy_free_merge_top.sv
tb/sv/buddy_merge_checker.sv
tb/sv/tb.sv
